// ===== rtl/core/pdfm_pkg.sv =====
// shared types and constants of the pwm duty and frequency meter
`default_nettype none

package pdfm_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_INVERT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_REF_CLK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HI_COST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LO_COST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OVERHEAD = 3'd5;

    // field widths
    localparam int TIMEOUT_W = 16;
    localparam int HIGH_W    = 16;
    localparam int COST_W    = 8;
    localparam int DUTY_W    = 7;
    localparam int FREQ_W    = 27;
    localparam int PERIOD_W  = 20;

    // divider numerator width (reference clock is the widest dividend)
    localparam int DIV_NUM_W = 27;

    // report queue depth between counter front and arithmetic back
    localparam int QUEUE_DEPTH = 4;

    // reset values of the configuration registers
    localparam logic                 RST_INVERT   = 1'b1;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT  = 16'd10000;
    localparam logic [FREQ_W-1:0]    RST_REF_CLK  = 27'd24000000;
    localparam logic [COST_W-1:0]    RST_HI_COST  = 8'd52;
    localparam logic [COST_W-1:0]    RST_LO_COST  = 8'd51;
    localparam logic [COST_W-1:0]    RST_OVERHEAD = 8'd2;

    // arithmetic constants
    localparam logic [DUTY_W-1:0]   PCT_SCALE = 7'd100;
    localparam logic [PERIOD_W-1:0] US_PER_S  = 20'd1000000;
    localparam logic [HIGH_W-1:0]   HIGH_MAX  = 16'hFFFF;

    typedef struct packed {
        logic                 invert_input;
        logic [TIMEOUT_W-1:0] timeout_samples;
        logic [FREQ_W-1:0]    reference_clock_hz;
        logic [COST_W-1:0]    high_sample_cost;
        logic [COST_W-1:0]    low_sample_cost;
        logic [COST_W-1:0]    cycle_overhead;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/pdfm_front.sv =====
// sample counter and report classifier, one sample per cycle while accept is high
`default_nettype none

module pdfm_front
    import pdfm_pkg::*;
#(
    parameter int LOW_COUNT_WIDTH = 24
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic                       level,
    input  wire cfg_t                       cfg,
    output logic                            report_valid,
    output logic [HIGH_W-1:0]               report_high,
    output logic [LOW_COUNT_WIDTH-1:0]      report_low
);

    localparam logic [LOW_COUNT_WIDTH-1:0] LOW_MAX = {LOW_COUNT_WIDTH{1'b1}};

    logic [HIGH_W-1:0]          high_count_reg, high_count_next;
    logic [LOW_COUNT_WIDTH-1:0] low_count_reg, low_count_next;
    logic                       armed_reg, armed_next;
    logic [TIMEOUT_W-1:0]       idle_count_reg, idle_count_next;
    logic                       sample_high;
    logic                       report;

    always_comb
    begin
        high_count_next = high_count_reg;
        low_count_next  = low_count_reg;
        armed_next      = armed_reg;
        idle_count_next = idle_count_reg;
        report          = 1'b0;
        sample_high     = level ^ cfg.invert_input;

        // timeout: report current counts and start over
        if (idle_count_reg == cfg.timeout_samples)
        begin
            report          = 1'b1;
            high_count_next = '0;
            low_count_next  = '0;
            armed_next      = 1'b0;
            idle_count_next = '0;
        end

        if (sample_high)
        begin
            if (low_count_next == '0)
            begin
                if (high_count_next == '0)
                begin
                    armed_next      = 1'b1;
                    idle_count_next = '0;
                end
                if (high_count_next != HIGH_MAX)
                begin
                    high_count_next = high_count_next + 16'd1;
                end
                idle_count_next = idle_count_next + 16'd1;
            end
            else
            begin
                // rising edge after the low run closes the period
                report          = 1'b1;
                high_count_next = '0;
                low_count_next  = '0;
                armed_next      = 1'b0;
                idle_count_next = '0;
            end
        end
        else if (armed_next)
        begin
            if (low_count_next != LOW_MAX)
            begin
                low_count_next = low_count_next + LOW_COUNT_WIDTH'(1);
            end
        end
        else
        begin
            idle_count_next = idle_count_next + 16'd1;
        end
    end

    // either report source snapshots the counts held before this sample
    assign report_valid = accept & report;
    assign report_high  = high_count_reg;
    assign report_low   = low_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_count_reg <= '0;
            low_count_reg  <= '0;
            armed_reg      <= 1'b0;
            idle_count_reg <= '0;
        end
        else if (accept)
        begin
            high_count_reg <= high_count_next;
            low_count_reg  <= low_count_next;
            armed_reg      <= armed_next;
            idle_count_reg <= idle_count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pdfm_queue.sv =====
// small report queue between counter front and arithmetic back
`default_nettype none

module pdfm_queue
    import pdfm_pkg::*;
#(
    parameter int WIDTH = 40
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  not_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push & ~full;
    assign do_pop    = pop & not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pdfm_divider.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none

module pdfm_divider
    import pdfm_pkg::*;
#(
    parameter int DEN_W = 33
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DIV_NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0]     den,
    output logic                      done,
    output logic [DIV_NUM_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0]       rem_shift;
    logic [DEN_W:0]       diff;

    // quo_reg shifts dividend bits out at the top and quotient bits in below
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_NUM_W-1]};
        diff      = rem_shift - {1'b0, den_reg};
        if (!diff[DEN_W])
        begin
            rem_next = diff[DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_shift[DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(DIV_NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (count_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg - CNT_W'(1);
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pdfm_back.sv =====
// report arithmetic: cost products, duty, frequency and period, output register
`default_nettype none

module pdfm_back
    import pdfm_pkg::*;
#(
    parameter int LOW_COUNT_WIDTH = 24
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cfg_t                       cfg,
    input  wire logic                       queue_valid,
    input  wire logic [HIGH_W-1:0]          queue_high,
    input  wire logic [LOW_COUNT_WIDTH-1:0] queue_low,
    output logic                            queue_pop,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            extreme,
    output logic [DUTY_W-1:0]               duty_percent,
    output logic [FREQ_W-1:0]               frequency_hz,
    output logic [PERIOD_W-1:0]             period_us,
    output logic [HIGH_W-1:0]               high_samples,
    output logic [LOW_COUNT_WIDTH-1:0]      low_samples
);

    localparam int PH_W    = HIGH_W + COST_W;
    localparam int PL_W    = LOW_COUNT_WIDTH + COST_W;
    localparam int SUM_W   = LOW_COUNT_WIDTH + 1;
    localparam int PCT_W   = HIGH_W + DUTY_W;
    localparam int COSTS_W = PL_W + 1;
    localparam int DEN_W   = (COSTS_W > DIV_NUM_W) ? COSTS_W : DIV_NUM_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_DUTY = 3'd3;
    localparam logic [2:0] S_FREQ = 3'd4;
    localparam logic [2:0] S_PER  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]                 state_reg, state_next;
    logic [HIGH_W-1:0]          hi_reg;
    logic [LOW_COUNT_WIDTH-1:0] lo_reg;
    logic [PH_W-1:0]            prod_h_reg;
    logic [PL_W-1:0]            prod_l_reg;
    logic [PCT_W-1:0]           pct_num_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [DEN_W-1:0]           den_reg;
    logic                       extreme_reg;
    logic [DUTY_W-1:0]          duty_reg;
    logic [FREQ_W-1:0]          freq_reg;
    logic [PERIOD_W-1:0]        period_reg;

    logic                       out_valid_reg;
    logic                       out_extreme_reg;
    logic [DUTY_W-1:0]          out_duty_reg;
    logic [FREQ_W-1:0]          out_freq_reg;
    logic [PERIOD_W-1:0]        out_period_reg;
    logic [HIGH_W-1:0]          out_high_reg;
    logic [LOW_COUNT_WIDTH-1:0] out_low_reg;

    logic                       div_start;
    logic [DIV_NUM_W-1:0]       div_num;
    logic [DEN_W-1:0]           div_den;
    logic                       div_done;
    logic [DIV_NUM_W-1:0]       div_quo;
    logic                       out_load;

    pdfm_divider #(
        .DEN_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        queue_pop  = 1'b0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (queue_valid)
                begin
                    queue_pop  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (hi_reg == '0 || lo_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                div_start  = 1'b1;
                div_num    = DIV_NUM_W'(pct_num_reg);
                div_den    = DEN_W'(sum_reg);
                state_next = S_DUTY;
            end
            S_DUTY:
            begin
                if (div_done)
                begin
                    div_start  = 1'b1;
                    div_num    = cfg.reference_clock_hz;
                    // all-zero costs count as one cycle
                    div_den    = (den_reg == '0) ? DEN_W'(1) : den_reg;
                    state_next = S_FREQ;
                end
            end
            S_FREQ:
            begin
                if (div_done)
                begin
                    if (div_quo == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_num    = DIV_NUM_W'(US_PER_S);
                        div_den    = DEN_W'(div_quo);
                        state_next = S_PER;
                    end
                end
            end
            S_PER:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                hi_reg <= queue_high;
                lo_reg <= queue_low;
            end
            S_MUL:
            begin
                prod_h_reg  <= PH_W'(hi_reg) * PH_W'(cfg.high_sample_cost);
                prod_l_reg  <= PL_W'(lo_reg) * PL_W'(cfg.low_sample_cost);
                pct_num_reg <= PCT_W'(hi_reg) * PCT_W'(PCT_SCALE);
                sum_reg     <= SUM_W'(hi_reg) + SUM_W'(lo_reg);
                extreme_reg <= (hi_reg == '0) || (lo_reg == '0);
                duty_reg    <= (hi_reg == '0) ? '0 : PCT_SCALE;
                freq_reg    <= '0;
                period_reg  <= '0;
            end
            S_SUM:
            begin
                den_reg <= DEN_W'(prod_h_reg) + DEN_W'(prod_l_reg)
                           + DEN_W'(cfg.cycle_overhead);
            end
            S_DUTY:
            begin
                if (div_done)
                begin
                    duty_reg <= div_quo[DUTY_W-1:0];
                end
            end
            S_FREQ:
            begin
                if (div_done)
                begin
                    freq_reg   <= div_quo[FREQ_W-1:0];
                    // zero frequency saturates the period
                    period_reg <= US_PER_S;
                end
            end
            S_PER:
            begin
                if (div_done)
                begin
                    period_reg <= div_quo[PERIOD_W-1:0];
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_extreme_reg <= extreme_reg;
            out_duty_reg    <= duty_reg;
            out_freq_reg    <= freq_reg;
            out_period_reg  <= period_reg;
            out_high_reg    <= hi_reg;
            out_low_reg     <= lo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign extreme      = out_extreme_reg;
    assign duty_percent = out_duty_reg;
    assign frequency_hz = out_freq_reg;
    assign period_us    = out_period_reg;
    assign high_samples = out_high_reg;
    assign low_samples  = out_low_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pwm_duty_frequency_meter_unit.sv =====
// top level of the pwm duty cycle and frequency meter
`default_nettype none

// channel  direction  handshake              payload
// in       sink       in_valid / in_ready    level
// out      source     out_valid / out_ready  extreme, duty_percent, frequency_hz,
//                                            period_us, high_samples, low_samples
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// samples are taken one per cycle while the report queue has room; the counter
// front waits on the arithmetic only while the report queue is full
// a measured report takes the back end through three passes of the shared
// 27-step restoring divider (duty, frequency, period) plus its control states;
// a zero frequency skips the period pass
// reports with a zero count skip the divider
// in_ready drops only while the four-entry report queue is full; a held output
// register adds its wait to the report in the back end
// reset clears counters, queue, sequencer and output valid; config registers
// return to their documented defaults; cfg_ready is always high

module pwm_duty_frequency_meter_unit
    import pdfm_pkg::*;
#(
    parameter int LOW_COUNT_WIDTH = 24
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       level,

    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            extreme,
    output logic [DUTY_W-1:0]               duty_percent,
    output logic [FREQ_W-1:0]               frequency_hz,
    output logic [PERIOD_W-1:0]             period_us,
    output logic [HIGH_W-1:0]               high_samples,
    output logic [LOW_COUNT_WIDTH-1:0]      low_samples,

    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data
);

    localparam int REPORT_W = HIGH_W + LOW_COUNT_WIDTH;

    cfg_t                       cfg_reg;
    logic                       in_transfer;
    logic                       queue_full;
    logic                       report_valid;
    logic [HIGH_W-1:0]          report_high;
    logic [LOW_COUNT_WIDTH-1:0] report_low;
    logic                       queue_not_empty;
    logic                       queue_pop;
    logic [REPORT_W-1:0]        queue_data;

    // configuration registers; unused indexes are ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.invert_input       <= RST_INVERT;
            cfg_reg.timeout_samples    <= RST_TIMEOUT;
            cfg_reg.reference_clock_hz <= RST_REF_CLK;
            cfg_reg.high_sample_cost   <= RST_HI_COST;
            cfg_reg.low_sample_cost    <= RST_LO_COST;
            cfg_reg.cycle_overhead     <= RST_OVERHEAD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IDX_INVERT:   cfg_reg.invert_input       <= cfg_data[0];
                CFG_IDX_TIMEOUT:  cfg_reg.timeout_samples    <= cfg_data[TIMEOUT_W-1:0];
                CFG_IDX_REF_CLK:  cfg_reg.reference_clock_hz <= cfg_data[FREQ_W-1:0];
                CFG_IDX_HI_COST:  cfg_reg.high_sample_cost   <= cfg_data[COST_W-1:0];
                CFG_IDX_LO_COST:  cfg_reg.low_sample_cost    <= cfg_data[COST_W-1:0];
                CFG_IDX_OVERHEAD: cfg_reg.cycle_overhead     <= cfg_data[COST_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // any sample may close a report, so hold off input while the queue is full
    assign in_ready    = ~queue_full;
    assign in_transfer = in_valid & in_ready;

    // counter front: one sample per transfer, emits count snapshots
    pdfm_front #(
        .LOW_COUNT_WIDTH (LOW_COUNT_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_transfer),
        .level        (level),
        .cfg          (cfg_reg),
        .report_valid (report_valid),
        .report_high  (report_high),
        .report_low   (report_low)
    );

    // snapshot queue decouples sampling from the slow arithmetic
    pdfm_queue #(
        .WIDTH (REPORT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (report_valid),
        .push_data ({report_high, report_low}),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_data  (queue_data),
        .not_empty (queue_not_empty)
    );

    // arithmetic back end with its own output register
    pdfm_back #(
        .LOW_COUNT_WIDTH (LOW_COUNT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .queue_valid  (queue_not_empty),
        .queue_high   (queue_data[REPORT_W-1:LOW_COUNT_WIDTH]),
        .queue_low    (queue_data[LOW_COUNT_WIDTH-1:0]),
        .queue_pop    (queue_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .extreme      (extreme),
        .duty_percent (duty_percent),
        .frequency_hz (frequency_hz),
        .period_us    (period_us),
        .high_samples (high_samples),
        .low_samples  (low_samples)
    );

endmodule

`default_nettype wire

// ===== sim/pdfm_report_checker.sv =====
// report checker for the pwm duty and frequency meter: predicts each report and compares
`timescale 1ns / 1ps

module pdfm_report_checker
    import pdfm_pkg::*;
#(
    parameter int LOW_COUNT_WIDTH = 24
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       level,

    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       extreme,
    input  logic [DUTY_W-1:0]          duty_percent,
    input  logic [FREQ_W-1:0]          frequency_hz,
    input  logic [PERIOD_W-1:0]        period_us,
    input  logic [HIGH_W-1:0]          high_samples,
    input  logic [LOW_COUNT_WIDTH-1:0] low_samples,

    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,

    output int                         fail_count,
    output int                         reports_pending
);

    typedef struct packed {
        logic                       extreme;
        logic [DUTY_W-1:0]          duty;
        logic [FREQ_W-1:0]          freq;
        logic [PERIOD_W-1:0]        period;
        logic [HIGH_W-1:0]          highs;
        logic [LOW_COUNT_WIDTH-1:0] lows;
    } report_t;

    localparam logic [LOW_COUNT_WIDTH-1:0] LOW_SAT = '1;

    // register copy
    logic                       invert_q;
    logic [TIMEOUT_W-1:0]       timeout_q;
    logic [FREQ_W-1:0]          ref_clk_q;
    logic [COST_W-1:0]          hi_cost_q;
    logic [COST_W-1:0]          lo_cost_q;
    logic [COST_W-1:0]          overhead_q;

    // pulse counters
    logic [HIGH_W-1:0]          high_run;
    logic [LOW_COUNT_WIDTH-1:0] low_run;
    logic                       armed_q;
    logic [TIMEOUT_W-1:0]       idle_run;

    report_t                    reports_due[$];
    int                         fails;

    function automatic report_t measure_pulse();
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned den;
        longint unsigned freq;
        report_t         r;
        hi = high_run;
        lo = low_run;
        r  = '0;
        if (hi != 0 && lo != 0)
        begin
            den = hi * hi_cost_q + lo * lo_cost_q + overhead_q;
            if (den == 0)
                den = 1;
            freq     = ref_clk_q / den;
            r.duty   = DUTY_W'((hi * PCT_SCALE) / (hi + lo));
            r.freq   = FREQ_W'(freq);
            r.period = (freq == 0) ? US_PER_S : PERIOD_W'(US_PER_S / freq);
        end
        else
        begin
            // timeout case, no period could be measured
            r.extreme = 1'b1;
            r.duty    = (hi == 0) ? '0 : PCT_SCALE;
        end
        r.highs = high_run;
        r.lows  = low_run;
        return r;
    endfunction

    task automatic restart_pulse();
        high_run = '0;
        low_run  = '0;
        armed_q  = 1'b0;
        idle_run = '0;
    endtask

    task automatic take_sample(input logic raw);
        logic hi_lvl;
        hi_lvl = raw ^ invert_q;
        if (idle_run == timeout_q)
        begin
            reports_due.push_back(measure_pulse());
            restart_pulse();
        end
        if (hi_lvl)
        begin
            if (low_run == '0)
            begin
                if (high_run == '0)
                begin
                    armed_q  = 1'b1;
                    idle_run = '0;
                end
                if (high_run != HIGH_MAX)
                    high_run++;
                idle_run++;
            end
            else
            begin
                // rising edge closes the period, the edge sample itself is dropped
                reports_due.push_back(measure_pulse());
                restart_pulse();
            end
        end
        else if (armed_q)
        begin
            if (low_run != LOW_SAT)
                low_run++;
        end
        else
            idle_run++;
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_IDX_INVERT:   invert_q   = data[0];
            CFG_IDX_TIMEOUT:  timeout_q  = data[TIMEOUT_W-1:0];
            CFG_IDX_REF_CLK:  ref_clk_q  = data[FREQ_W-1:0];
            CFG_IDX_HI_COST:  hi_cost_q  = data[COST_W-1:0];
            CFG_IDX_LO_COST:  lo_cost_q  = data[COST_W-1:0];
            CFG_IDX_OVERHEAD: overhead_q = data[COST_W-1:0];
            default:          ;
        endcase
    endtask

    function automatic bit field_ok(input string name, input longint unsigned want,
                                    input longint unsigned got);
        if (want != got)
            $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
        return want == got;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        report_t want;
        report_t got;
        bit      ok;
        if (!rst_n)
        begin
            invert_q   = RST_INVERT;
            timeout_q  = RST_TIMEOUT;
            ref_clk_q  = RST_REF_CLK;
            hi_cost_q  = RST_HI_COST;
            lo_cost_q  = RST_LO_COST;
            overhead_q = RST_OVERHEAD;
            restart_pulse();
            reports_due.delete();
            fails = 0;
            fail_count      <= 0;
            reports_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            if (in_valid && in_ready)
                take_sample(level);
            if (out_valid && out_ready)
            begin
                got.extreme = extreme;
                got.duty    = duty_percent;
                got.freq    = frequency_hz;
                got.period  = period_us;
                got.highs   = high_samples;
                got.lows    = low_samples;
                if (reports_due.size() == 0)
                begin
                    $display("%0t: report with none expected: extreme %0d duty %0d freq %0d",
                             $time, got.extreme, got.duty, got.freq);
                    fails++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    ok = field_ok("extreme", want.extreme, got.extreme)
                       & field_ok("duty_percent", want.duty, got.duty)
                       & field_ok("frequency_hz", want.freq, got.freq)
                       & field_ok("period_us", want.period, got.period)
                       & field_ok("high_samples", want.highs, got.highs)
                       & field_ok("low_samples", want.lows, got.lows);
                    if (!ok)
                        fails++;
                end
            end
            fail_count      <= fails;
            reports_pending <= reports_due.size();
        end
    end

endmodule

// ===== sim/tb_pwm_duty_frequency_meter_unit.sv =====
// testbench top for the pwm duty and frequency meter: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_pwm_duty_frequency_meter_unit
    import pdfm_pkg::*;
;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 3;
    localparam int LOW_W          = 24;
    // idle wait after the expected reports, long enough to cover reports in flight in the back end
    localparam int DRAIN_CYCLES   = 200;
    localparam int HOLD_CYCLES    = 2000;
    localparam int CYCLE_LIMIT    = 1500000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 100;
    localparam int CALM_PHASE     = 3;
    localparam int PRESSURE_PHASE = 5;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;

    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  level     = 1'b0;

    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  extreme;
    logic [DUTY_W-1:0]     duty_percent;
    logic [FREQ_W-1:0]     frequency_hz;
    logic [PERIOD_W-1:0]   period_us;
    logic [HIGH_W-1:0]     high_samples;
    logic [LOW_W-1:0]      low_samples;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int reports_pending;

    // stimulus side view of the invert bit, so pulses are built in measured polarity
    bit inv_now  = RST_INVERT;
    // no random idling on either side while set
    bit no_idle  = 1'b0;
    // asks the receiver for one long hold-off
    bit hold_req = 1'b0;
    int items_sent = 0;
    int cycle_count = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    pwm_duty_frequency_meter_unit #(
        .LOW_COUNT_WIDTH (LOW_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .level        (level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .extreme      (extreme),
        .duty_percent (duty_percent),
        .frequency_hz (frequency_hz),
        .period_us    (period_us),
        .high_samples (high_samples),
        .low_samples  (low_samples),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // watches all three channels and keeps the expected reports
    pdfm_report_checker #(
        .LOW_COUNT_WIDTH (LOW_W)
    ) scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .level           (level),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .extreme         (extreme),
        .duty_percent    (duty_percent),
        .frequency_hz    (frequency_hz),
        .period_us       (period_us),
        .high_samples    (high_samples),
        .low_samples     (low_samples),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .reports_pending (reports_pending)
    );

    // watchdog: a hung handshake or a report that never shows up ends here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL pwm_duty_frequency_meter_unit");
            $finish;
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request so the
    // report queue fills and in_ready drops
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                out_ready <= no_idle || ($urandom_range(99) >= 16);
                @(posedge clk);
            end
        end
    end

    // one sample transfer; random idle cycles go in front of it
    task automatic send_raw(input logic raw);
        int gap;
        gap = 0;
        if (!no_idle)
            while ($urandom_range(99) < 16)
                gap++;
        cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        level    <= raw;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // sample in measured polarity, i.e. after the block's inversion
    task automatic send_level(input logic meas);
        send_raw(meas ^ inv_now);
    endtask

    // high run, low run, then the rising edge that closes the period
    task automatic pulse(input int highs, input int lows);
        repeat (highs) send_level(1'b1);
        repeat (lows) send_level(1'b0);
        send_level(1'b1);
    endtask

    // register write; bits above the register width carry random junk
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        int                    w;
        logic [CFG_DATA_W-1:0] junk;
        case (idx)
            CFG_IDX_INVERT:   w = 1;
            CFG_IDX_TIMEOUT:  w = TIMEOUT_W;
            CFG_IDX_REF_CLK:  w = FREQ_W;
            CFG_IDX_HI_COST,
            CFG_IDX_LO_COST,
            CFG_IDX_OVERHEAD: w = COST_W;
            default:          w = 0;
        endcase
        junk = CFG_DATA_W'($urandom) << w;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= junk | CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_IDX_INVERT)
            inv_now = value[0];
    endtask

    // stop offering, wait for every expected report, then let the back end go quiet
    task automatic settle();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge clk);
        while (reports_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly short runs, now and then a long one
    function automatic int run_len();
        return ($urandom_range(99) < 90) ? $urandom_range(1, 10) : $urandom_range(11, 80);
    endfunction

    // cost or overhead value, with the extremes well represented
    function automatic int unsigned pick_byte();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    initial
    begin
        int          phase_start;
        int          r;
        int unsigned tmo;
        int unsigned ref_hz;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset defaults first: plain measured periods
        pulse(3, 2);
        pulse(1, 1);

        // timeout on idle samples: duty 0 reports
        settle();
        write_reg(CFG_IDX_TIMEOUT, 1);
        repeat (3) send_level(1'b0);

        // timeout on a long high run: duty 100 report
        settle();
        write_reg(CFG_IDX_TIMEOUT, 2);
        repeat (3) send_level(1'b1);

        // timeout of zero fires right after the clear of a measured report
        settle();
        write_reg(CFG_IDX_TIMEOUT, 0);
        pulse(1, 1);
        send_level(1'b0);

        // all costs and overhead zero: denominator forced to one
        settle();
        write_reg(CFG_IDX_TIMEOUT, RST_TIMEOUT);
        write_reg(CFG_IDX_HI_COST, 0);
        write_reg(CFG_IDX_LO_COST, 0);
        write_reg(CFG_IDX_OVERHEAD, 0);
        pulse(2, 2);

        // zero reference clock: frequency zero, period saturated
        settle();
        write_reg(CFG_IDX_HI_COST, 1);
        write_reg(CFG_IDX_LO_COST, 1);
        write_reg(CFG_IDX_REF_CLK, 0);
        pulse(1, 1);

        // random phases, each with its own register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle();
            no_idle = (ph == CALM_PHASE);
            write_reg(CFG_IDX_INVERT, $urandom_range(1));
            case ($urandom_range(3))
                0:       tmo = $urandom_range(1, 30);
                1:       tmo = $urandom_range(31, 300);
                2:       tmo = 65535;
                default: tmo = $urandom_range(65535);
            endcase
            write_reg(CFG_IDX_TIMEOUT, tmo);
            case ($urandom_range(4))
                0:       ref_hz = 1;
                1:       ref_hz = 100000000;
                2:       ref_hz = 27'h7FFFFFF;
                3:       ref_hz = RST_REF_CLK;
                default: ref_hz = $urandom_range(1, 100000000);
            endcase
            write_reg(CFG_IDX_REF_CLK, ref_hz);
            write_reg(CFG_IDX_HI_COST, pick_byte());
            write_reg(CFG_IDX_LO_COST, pick_byte());
            write_reg(CFG_IDX_OVERHEAD, pick_byte());
            if (ph == 0)
            begin
                // writes to unmapped indexes must leave everything alone
                write_reg(CFG_IDX_SPARE_A, $urandom);
                write_reg(CFG_IDX_SPARE_B, $urandom);
            end
            if (ph == PRESSURE_PHASE)
                hold_req = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                r = $urandom_range(99);
                if (ph == PRESSURE_PHASE)
                    pulse(1, $urandom_range(1, 2));   // a report every few samples
                else if (r < 75)
                    pulse(run_len(), run_len());
                else if (r < 85)
                    repeat ($urandom_range(1, 40)) send_level(1'b1);
                else
                    repeat ($urandom_range(1, 8)) send_raw($urandom_range(1));
            end
        end

        settle();
        if (fail_count == 0)
            $display("PASS pwm_duty_frequency_meter_unit");
        else
            $display("FAIL pwm_duty_frequency_meter_unit");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pdfm_pkg.sv
rtl/core/pdfm_front.sv
rtl/core/pdfm_queue.sv
rtl/core/pdfm_divider.sv
rtl/core/pdfm_back.sv
rtl/core/pwm_duty_frequency_meter_unit.sv
sim/pdfm_report_checker.sv
sim/tb_pwm_duty_frequency_meter_unit.sv
